FILE: sv/lgge_pkg.sv
package lgge_pkg;

  localparam int DEF_GRID_W = 16;
  localparam int DEF_GRID_H = 16;

  localparam int COORD_W = 6;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [1:0] {
    CMD_TOGGLE,
    CMD_STEP,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_LOAD,
    ST_SWEEP
  } back_state_t;

endpackage

FILE: sv/lgge_front.sv
module lgge_front
  import lgge_pkg::*;
#(
  parameter int GRID_W = DEF_GRID_W,
  parameter int GRID_H = DEF_GRID_H
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  cmd_t             entry;
  logic             push;
  logic             pop;

  // clamp coordinates past the grid and decode the opcode
  always_comb begin
    entry.x = ({1'b0, in_x} >= (COORD_W+1)'(GRID_W)) ? COORD_W'(GRID_W - 1) : in_x;
    entry.y = ({1'b0, in_y} >= (COORD_W+1)'(GRID_H)) ? COORD_W'(GRID_H - 1) : in_y;
    case (in_opcode)
      OP_TOGGLE: entry.kind = CMD_TOGGLE;
      OP_STEP:   entry.kind = CMD_STEP;
      OP_READ:   entry.kind = CMD_READ;
      default:   entry.kind = CMD_READ;
    endcase
  end

  assign in_ready  = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

FILE: sv/lgge_back.sv
module lgge_back
  import lgge_pkg::*;
#(
  parameter int GRID_W = DEF_GRID_W,
  parameter int GRID_H = DEF_GRID_H
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_row,
  output logic [GRID_W-1:0]  out_bits,
  output logic               out_alive,
  output logic               out_last
);

  localparam int AW = $clog2(GRID_H);
  localparam int XW = $clog2(GRID_W);
  localparam int CW = $clog2(GRID_H + 4);

  back_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  cmd_t          cmd_r;

  // row store, one row per entry; rows never written read as dead
  logic [GRID_W-1:0] mem [GRID_H];
  logic [GRID_H-1:0] vld_r;
  logic [GRID_W-1:0] rdata_r;
  logic              rvld_r;
  logic [GRID_W-1:0] rd_row;

  // three-row window plus the original top two rows for the wrap at the bottom
  logic [GRID_W-1:0] prev_r, cur_r, next_r;
  logic [GRID_W-1:0] row0_r, row1_r;
  logic [GRID_W-1:0] life_row;

  logic [COORD_W-1:0] out_row_r;
  logic [GRID_W-1:0]  out_bits_r;
  logic               out_valid_r, out_alive_r, out_last_r;
  logic               out_free;

  logic              take_cmd;
  logic              rd_en, wr_en, emit, shift_win, save0, save1;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [GRID_W-1:0] wr_data, win_in, cell_row;
  logic [COORD_W-1:0] emit_row;
  logic              emit_alive, emit_last;

  assign out_free = !out_valid_r || out_ready;
  assign rd_row   = rvld_r ? rdata_r : '0;
  assign cell_row = rd_row ^ ((cmd_r.kind == CMD_TOGGLE) ?
                    (GRID_W'(1) << cmd_r.x[XW-1:0]) : '0);

  // B3/S23 on one row, columns wrap around
  for (genvar gx = 0; gx < GRID_W; gx++) begin : g_col
    localparam int L = (gx == 0) ? GRID_W - 1 : gx - 1;
    localparam int R = (gx == GRID_W - 1) ? 0 : gx + 1;
    logic [3:0] n;
    assign n = 4'(prev_r[L]) + 4'(prev_r[gx]) + 4'(prev_r[R]) + 4'(cur_r[L]) +
               4'(cur_r[R]) + 4'(next_r[L]) + 4'(next_r[gx]) + 4'(next_r[R]);
    assign life_row[gx] = (n == BIRTH_COUNT) || (cur_r[gx] && (n == SURVIVE_COUNT));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (cmd_valid) begin
          state_nxt = (cmd.kind == CMD_STEP) ? ST_LOAD : ST_CELL_RD;
        end
      end
      ST_CELL_RD: state_nxt = ST_CELL_WR;
      ST_CELL_WR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (cnt_r == CW'(3)) begin
          state_nxt = ST_SWEEP;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_SWEEP: begin
        if (out_free) begin
          if (cnt_r == CW'(GRID_H - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    take_cmd   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    emit       = 1'b0;
    emit_row   = '0;
    emit_alive = 1'b0;
    emit_last  = 1'b0;
    shift_win  = 1'b0;
    save0      = 1'b0;
    save1      = 1'b0;
    win_in     = rd_row;
    case (state_r)
      ST_IDLE: take_cmd = 1'b1;
      ST_CELL_RD: begin
        rd_en   = 1'b1;
        rd_addr = cmd_r.y[AW-1:0];
      end
      ST_CELL_WR: begin
        if (out_free) begin
          wr_en      = 1'b1;
          wr_addr    = cmd_r.y[AW-1:0];
          wr_data    = cell_row;
          emit       = 1'b1;
          emit_row   = cmd_r.y;
          emit_alive = cell_row[cmd_r.x[XW-1:0]];
          emit_last  = 1'b1;
        end
      end
      ST_LOAD: begin
        // reads rows H-1, 0, 1, 2; each arriving row shifts into the window
        rd_en     = 1'b1;
        rd_addr   = (cnt_r == '0) ? AW'(GRID_H - 1) : AW'(cnt_r - CW'(1));
        shift_win = (cnt_r != '0);
        save0     = (cnt_r == CW'(2));
        save1     = (cnt_r == CW'(3));
      end
      ST_SWEEP: begin
        if (out_free) begin
          wr_en     = 1'b1;
          wr_addr   = AW'(cnt_r);
          wr_data   = life_row;
          emit      = 1'b1;
          emit_row  = COORD_W'(cnt_r);
          emit_last = (cnt_r == CW'(GRID_H - 1));
          shift_win = 1'b1;
          // rows 0 and 1 are already rewritten when the bottom wraps to them
          if (cnt_r + CW'(2) == CW'(GRID_H)) begin
            win_in = row0_r;
          end else if (cnt_r + CW'(2) == CW'(GRID_H + 1)) begin
            win_in = row1_r;
          end
          rd_en   = (cnt_r + CW'(3) < CW'(GRID_H));
          rd_addr = AW'(cnt_r + CW'(3));
        end
      end
      default: ;
    endcase
  end

  assign cmd_ready = take_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd && cmd_valid) begin
      cmd_r <= cmd;
    end
    if (shift_win) begin
      prev_r <= cur_r;
      cur_r  <= next_r;
      next_r <= win_in;
    end
    if (save0) begin
      row0_r <= rd_row;
    end
    if (save1) begin
      row1_r <= rd_row;
    end
    if (emit) begin
      out_row_r   <= emit_row;
      out_bits_r  <= emit ? ((state_r == ST_SWEEP) ? life_row : cell_row) : out_bits_r;
      out_alive_r <= emit_alive;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_bits  = out_bits_r;
  assign out_alive = out_alive_r;
  assign out_last  = out_last_r;

endmodule

FILE: sv/life_grid_generation_engine.sv
// Game of Life (B3/S23) engine on a torus of GRID_W columns by GRID_H rows.
// Input stream: in_tdata carries opcode, cell_x, cell_y. Toggle flips one
// cell, read reports one cell; each gives one output transfer with the
// clamped row index, that row's bits and the cell state, tlast set.
// Step computes the next generation and gives GRID_H output transfers, one
// per row in order, tlast on the last row.
// Items pass through a two-entry queue into the execution unit, so the
// input side keeps taking transfers until the queue fills while a result waits on out_tready.
// A toggle or read takes the item, reads the cell's row and writes it
// back, flipped for a toggle. A step takes the item, primes its three-row
// window from the row store, then gives one row per cycle while out_tready
// allows. The execution unit takes a new item only when it is done with
// the last one. The row store has a single read port.
// If out_tready is low the sweep waits on that row; nothing is dropped.
// Reset (rst_n low, synchronous) empties the queue and marks every row dead.
module life_grid_generation_engine
  import lgge_pkg::*;
#(
  parameter int GRID_W = DEF_GRID_W,
  parameter int GRID_H = DEF_GRID_H
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] opcode, [7:2] cell_x, [13:8] cell_y, [15:14] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [5:0] row_index, [69:6] row_bits, [70] cell_alive, [71] zero
  output logic        out_tlast
);

  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;
  logic [COORD_W-1:0] row;
  logic [GRID_W-1:0]  bits;
  logic               alive;

  lgge_front #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_opcode(in_tdata[1:0]),
    .in_x     (in_tdata[7:2]),
    .in_y     (in_tdata[13:8]),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  lgge_back #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_row  (row),
    .out_bits (bits),
    .out_alive(alive),
    .out_last (out_tlast)
  );

  assign out_tdata = {1'b0, alive, 64'(bits), row};

endmodule
